/* hw/rtl/cau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared types, operation codes and saturation helpers for the complex unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;

	// Operation codes.
	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_NEG = 3'd4,
		CMD_CMP = 3'd5
	} cmd_t;

	// One operation request.
	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] a_real;
		logic signed [31:0] a_imag;
		logic signed [31:0] b_real;
		logic signed [31:0] b_imag;
	} in_t;

	// One result.
	typedef struct packed {
		logic signed [31:0] result_real;
		logic signed [31:0] result_imag;
		logic               is_equal;
		logic               divide_by_zero;
		logic               saturated;
	} out_t;

	// Side information that travels alongside the divider chain.
	typedef struct packed {
		out_t res;
		logic is_div;
		logic neg_re;
		logic neg_im;
		logic ovf_re;
		logic ovf_im;
	} side_t;

	// Sign extend the low ew bits of a field to 32 bits.
	function automatic logic signed [31:0] sext_word(input logic [31:0] raw, input int ew);
		logic signed [31:0] t;
		t = $signed(raw << (32 - ew));
		return t >>> (32 - ew);
	endfunction

	// Clamp to the signed ew-bit range; bit 32 is the saturation flag.
	function automatic logic [32:0] clamp_word(input logic signed [65:0] v, input int ew);
		logic signed [65:0] hi_lim;
		logic signed [65:0] lo_lim;
		logic [32:0]        r;
		hi_lim = (66'sd1 <<< (ew - 1)) - 66'sd1;
		lo_lim = -(66'sd1 <<< (ew - 1));
		priority if (v > hi_lim) begin
			r = {1'b1, hi_lim[31:0]};
		end else if (v < lo_lim) begin
			r = {1'b1, lo_lim[31:0]};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

/* hw/rtl/cau_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step for the real and imaginary quotients, sharing a divisor.
// ----------------------------------------------------------------------------
module cau_div_cell #(
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic [63:0]   den_i,
	input  logic [63:0]   rem_re_i,
	input  logic [63:0]   rem_im_i,
	input  logic [QW-1:0] nlo_re_i,
	input  logic [QW-1:0] nlo_im_i,
	input  logic [QW-1:0] q_re_i,
	input  logic [QW-1:0] q_im_i,
	output logic [63:0]   den_o,
	output logic [63:0]   rem_re_o,
	output logic [63:0]   rem_im_o,
	output logic [QW-1:0] nlo_re_o,
	output logic [QW-1:0] nlo_im_o,
	output logic [QW-1:0] q_re_o,
	output logic [QW-1:0] q_im_o
);
	logic [64:0] trial_re, trial_im, diff_re, diff_im;
	logic        ge_re, ge_im;

	// Bring down the next numerator bit and try the subtraction.
	always_comb begin
		trial_re = {rem_re_i, nlo_re_i[QW-1]};
		trial_im = {rem_im_i, nlo_im_i[QW-1]};
		diff_re  = trial_re - {1'b0, den_i};
		diff_im  = trial_im - {1'b0, den_i};
		ge_re    = trial_re >= {1'b0, den_i};
		ge_im    = trial_im >= {1'b0, den_i};
	end

	// Hand the partial remainders and quotients to the next cell.
	always_ff @(posedge clk) begin
		den_o    <= den_i;
		rem_re_o <= ge_re ? diff_re[63:0] : trial_re[63:0];
		rem_im_o <= ge_im ? diff_im[63:0] : trial_im[63:0];
		nlo_re_o <= {nlo_re_i[QW-2:0], 1'b0};
		nlo_im_o <= {nlo_im_i[QW-2:0], 1'b0};
		q_re_o   <= {q_re_i[QW-2:0], ge_re};
		q_im_o   <= {q_im_i[QW-2:0], ge_im};
	end

endmodule

/* hw/rtl/complex_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined add, subtract, multiply, divide, negate and compare on complex
// signed fixed-point operands, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
// Usage:
// A request transfers on a rising edge with start high and busy low. Busy is
// always low, so a new request may be given every cycle. Each request gives
// exactly one result, shown on the result port for one cycle with done high;
// results come out in request order.
// Every operation takes the same path, set by the divider: a chain of one
// restoring cell per quotient bit behind two multiply/sum stages and a setup
// stage; all other operations travel alongside it. Above 32 bits the word
// acts as 32.
// Throughput is one operation per cycle.
// Reset clears all valid bits; no result appears from work in flight.
// The receiver cannot stall: a result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  cau_pkg::in_t  operands,
	output logic          done,
	output cau_pkg::out_t result
);
	import cau_pkg::*;

	localparam int EW  = (WORD_BITS > 32) ? 32 : WORD_BITS;
	localparam int NW  = 64 + FRAC_BITS;
	localparam int HW  = NW - EW;
	localparam int CW  = (HW > 64) ? HW : 64;
	localparam int LAT = EW + 4;

	logic accept;
	logic signed [31:0] ar0, ai0, br0, bi0;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_comb begin
		ar0 = sext_word(operands.a_real, EW);
		ai0 = sext_word(operands.a_imag, EW);
		br0 = sext_word(operands.b_real, EW);
		bi0 = sext_word(operands.b_imag, EW);
	end

	// Stage 1: all partial products.
	logic               vld_s1;
	logic [2:0]         cmd_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_br_s1, p_bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= operands.cmd;
		ar_s1   <= ar0;
		ai_s1   <= ai0;
		br_s1   <= br0;
		bi_s1   <= bi0;
		p_rr_s1 <= 64'(ar0) * 64'(br0);
		p_ii_s1 <= 64'(ai0) * 64'(bi0);
		p_ri_s1 <= 64'(ar0) * 64'(bi0);
		p_ir_s1 <= 64'(ai0) * 64'(br0);
		p_br_s1 <= 64'(br0) * 64'(br0);
		p_bi_s1 <= 64'(bi0) * 64'(bi0);
	end

	// Stage 2: product sums, dividend magnitudes and the divisor.
	logic signed [64:0] mre_c, mim_c, nre_c, nim_c, nre_n, nim_n;
	logic               vld_s2;
	logic [2:0]         cmd_s2;
	logic signed [31:0] ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [64:0] mre_s2, mim_s2;
	logic [63:0]        nre_s2, nim_s2, den_s2;
	logic               nre_neg_s2, nim_neg_s2;

	always_comb begin
		mre_c = (65'(p_rr_s1) - 65'(p_ii_s1)) >>> FRAC_BITS;
		mim_c = (65'(p_ri_s1) + 65'(p_ir_s1)) >>> FRAC_BITS;
		nre_c = 65'(p_rr_s1) + 65'(p_ii_s1);
		nre_n = -65'(p_rr_s1) - 65'(p_ii_s1);
		nim_c = 65'(p_ir_s1) - 65'(p_ri_s1);
		nim_n = 65'(p_ri_s1) - 65'(p_ir_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2     <= cmd_s1;
		ar_s2      <= ar_s1;
		ai_s2      <= ai_s1;
		br_s2      <= br_s1;
		bi_s2      <= bi_s1;
		mre_s2     <= mre_c;
		mim_s2     <= mim_c;
		nre_neg_s2 <= nre_c[64];
		nim_neg_s2 <= nim_c[64];
		nre_s2     <= nre_c[64] ? nre_n[63:0] : nre_c[63:0];
		nim_s2     <= nim_c[64] ? nim_n[63:0] : nim_c[63:0];
		den_s2     <= 64'(p_br_s1) + 64'(p_bi_s1);
	end

	// Stage 3: simple results, divider setup and overflow precheck.
	logic [NW-1:0] nre_w, nim_w;
	logic [HW-1:0] hre, him;
	logic [32:0]   cl_re, cl_im;
	side_t         side_c0;

	always_comb begin
		nre_w = NW'(nre_s2) << FRAC_BITS;
		nim_w = NW'(nim_s2) << FRAC_BITS;
		hre   = nre_w[NW-1:EW];
		him   = nim_w[NW-1:EW];
		cl_re = '0;
		cl_im = '0;
		side_c0 = '0;
		unique case (cmd_s2)
			CMD_ADD: begin
				cl_re = clamp_word(66'(ar_s2) + 66'(br_s2), EW);
				cl_im = clamp_word(66'(ai_s2) + 66'(bi_s2), EW);
			end
			CMD_SUB: begin
				cl_re = clamp_word(66'(ar_s2) - 66'(br_s2), EW);
				cl_im = clamp_word(66'(ai_s2) - 66'(bi_s2), EW);
			end
			CMD_MUL: begin
				cl_re = clamp_word(66'(mre_s2), EW);
				cl_im = clamp_word(66'(mim_s2), EW);
			end
			CMD_DIV: begin
				side_c0.is_div             = 1'b1;
				side_c0.res.divide_by_zero = (den_s2 == 64'd0);
			end
			CMD_NEG: begin
				cl_re = clamp_word(-66'(ar_s2), EW);
				cl_im = clamp_word(-66'(ai_s2), EW);
			end
			CMD_CMP: begin
				side_c0.res.is_equal = (ar_s2 == br_s2) && (ai_s2 == bi_s2);
			end
			default: begin
			end
		endcase
		side_c0.res.result_real = cl_re[31:0];
		side_c0.res.result_imag = cl_im[31:0];
		side_c0.res.saturated   = cl_re[32] | cl_im[32];
		side_c0.neg_re          = nre_neg_s2;
		side_c0.neg_im          = nim_neg_s2;
		side_c0.ovf_re          = CW'(hre) >= CW'(den_s2);
		side_c0.ovf_im          = CW'(him) >= CW'(den_s2);
	end

	// Divider chain: one cell per quotient bit, side data delayed alongside.
	logic [63:0]   den_c    [0:EW];
	logic [63:0]   rem_re_c [0:EW];
	logic [63:0]   rem_im_c [0:EW];
	logic [EW-1:0] nlo_re_c [0:EW];
	logic [EW-1:0] nlo_im_c [0:EW];
	logic [EW-1:0] q_re_c   [0:EW];
	logic [EW-1:0] q_im_c   [0:EW];
	side_t         side_q   [0:EW];
	logic          vld_q    [0:EW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else begin
			vld_q[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_q[0]   <= side_c0;
		den_c[0]    <= den_s2;
		rem_re_c[0] <= 64'(hre);
		rem_im_c[0] <= 64'(him);
		nlo_re_c[0] <= nre_w[EW-1:0];
		nlo_im_c[0] <= nim_w[EW-1:0];
	end

	assign q_re_c[0] = '0;
	assign q_im_c[0] = '0;

	for (genvar k = 0; k < EW; k++) begin : g_cell
		cau_div_cell #(
			.QW(EW)
		) u_cell (
			.clk     (clk),
			.den_i   (den_c[k]),
			.rem_re_i(rem_re_c[k]),
			.rem_im_i(rem_im_c[k]),
			.nlo_re_i(nlo_re_c[k]),
			.nlo_im_i(nlo_im_c[k]),
			.q_re_i  (q_re_c[k]),
			.q_im_i  (q_im_c[k]),
			.den_o   (den_c[k+1]),
			.rem_re_o(rem_re_c[k+1]),
			.rem_im_o(rem_im_c[k+1]),
			.nlo_re_o(nlo_re_c[k+1]),
			.nlo_im_o(nlo_im_c[k+1]),
			.q_re_o  (q_re_c[k+1]),
			.q_im_o  (q_im_c[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			side_q[k+1] <= side_q[k];
		end
	end

	// Output stage: sign and clamp the quotients, pick the result.
	logic signed [65:0] dv_re, dv_im;
	logic [32:0]        dc_re, dc_im;
	side_t              side_end;
	out_t               res_c;
	logic               done_q;
	out_t               result_q;

	always_comb begin
		side_end = side_q[EW];
		dv_re = side_end.ovf_re ? (66'sd1 <<< 40) : 66'(q_re_c[EW]);
		dv_im = side_end.ovf_im ? (66'sd1 <<< 40) : 66'(q_im_c[EW]);
		if (side_end.neg_re) begin
			dv_re = -dv_re;
		end
		if (side_end.neg_im) begin
			dv_im = -dv_im;
		end
		dc_re = clamp_word(dv_re, EW);
		dc_im = clamp_word(dv_im, EW);
		res_c = side_end.res;
		if (side_end.is_div && !side_end.res.divide_by_zero) begin
			res_c.result_real = dc_re[31:0];
			res_c.result_imag = dc_im[31:0];
			res_c.saturated   = dc_re[32] | dc_im[32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[EW];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	// Every transfer gives its result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result missing after fixed latency");

	// Divide by zero gives a zero, unsaturated result.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.divide_by_zero) |->
		(result.result_real == 32'sd0 && result.result_imag == 32'sd0 && !result.saturated))
		else $error("divide by zero result not cleared");

	// A compare gives a zero result and never saturates.
	a_eq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_equal) |->
		(result.result_real == 32'sd0 && result.result_imag == 32'sd0 && !result.saturated))
		else $error("compare result not cleared");

	// Equality and divide by zero come from different operations.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.is_equal && result.divide_by_zero))
		else $error("conflicting flags");
`endif

endmodule
